// ----- rtl/esa_pkg.sv -----
package esa_pkg;

    localparam int MAX_PAIRS   = 65536;
    localparam int SAMPLE_W    = 32;
    localparam int CNT_W       = $clog2(MAX_PAIRS + 1);
    localparam int ABS_W       = 48;
    localparam int SQ_W        = 64;
    localparam int WIDE_W      = 96;
    localparam int ACC_W       = 14;
    localparam int STAT_W      = 2;
    localparam int PERCENT_SQ  = 10000;

    // iteration counts of the shared unit
    localparam int MUL_STEPS   = SQ_W;
    localparam int DIV_STEPS   = WIDE_W;
    localparam int SQRT_STEPS  = SQ_W / 2;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_SINGLE    = 2'd1,
        STAT_SATURATED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } t_op;

    typedef enum logic [3:0] {
        FS_IDLE,
        FS_ACC_MUL,
        FS_ACC_DIV,
        FS_MAE_DIV,
        FS_RMS_DIV,
        FS_RMS_SQRT,
        FS_BIG_MUL,
        FS_S2_MUL,
        FS_DEV_DIV1,
        FS_DEV_DIV2,
        FS_DEV_SQRT,
        FS_OUT
    } t_fin_state;

    typedef struct packed {
        logic              start;
        t_op               op;
        logic [WIDE_W-1:0] opa;
        logic [SQ_W-1:0]   opb;
    } t_unit_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] pairs;
        logic [CNT_W-1:0] match_cnt;
        logic [ABS_W-1:0] abs_sum;
        logic [SQ_W-1:0]  sq_sum;
        logic             ovf;
    } t_accum_sums;

endpackage

// ----- rtl/esa_accum.sv -----
module esa_accum import esa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic [SAMPLE_W-1:0] i_sample_a,
    input  logic [SAMPLE_W-1:0] i_sample_b,
    input  logic                i_last,
    input  logic                i_clear,
    output t_accum_sums         o_sums,
    output logic                o_fin
);

    logic signed [SAMPLE_W:0] w_sub;
    logic signed [SAMPLE_W:0] w_mag;
    logic [SQ_W:0]            w_sq_total;

    logic                     r_s1_vld;
    logic                     r_s1_last;
    logic [SAMPLE_W-1:0]      r_s1_diff;
    logic                     r_s2_vld;
    logic                     r_s2_last;
    logic [SAMPLE_W-1:0]      r_s2_diff;
    logic [SQ_W-1:0]          r_s2_sq;
    t_accum_sums              r_sums;
    logic                     r_fin;

    assign w_sub = {i_sample_a[SAMPLE_W-1], i_sample_a} - {i_sample_b[SAMPLE_W-1], i_sample_b};
    assign w_mag = w_sub[SAMPLE_W] ? -w_sub : w_sub;
    assign w_sq_total = {1'b0, r_sums.sq_sum} + {1'b0, r_s2_sq};

    // stage 1: absolute difference
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_take;
        end
        if (i_take) begin
            r_s1_diff <= w_mag[SAMPLE_W-1:0];
            r_s1_last <= i_last;
        end
    end

    // stage 2: square
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        if (r_s1_vld) begin
            r_s2_diff <= r_s1_diff;
            r_s2_sq   <= SQ_W'(r_s1_diff) * SQ_W'(r_s1_diff);
            r_s2_last <= r_s1_last;
        end
    end

    // stage 3: running sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_sums <= '0;
            r_fin  <= 1'b0;
        end else begin
            r_fin <= r_s2_vld && r_s2_last;
            if (r_s2_vld) begin
                if (r_sums.pairs >= CNT_W'(MAX_PAIRS)) begin
                    r_sums.ovf <= 1'b1;
                end else begin
                    r_sums.pairs   <= r_sums.pairs + 1'b1;
                    r_sums.abs_sum <= r_sums.abs_sum + ABS_W'(r_s2_diff);
                    if (r_s2_diff == '0) begin
                        r_sums.match_cnt <= r_sums.match_cnt + 1'b1;
                    end
                    if (w_sq_total[SQ_W]) begin
                        r_sums.sq_sum <= '1;
                        r_sums.ovf    <= 1'b1;
                    end else begin
                        r_sums.sq_sum <= w_sq_total[SQ_W-1:0];
                    end
                end
            end
        end
    end

    assign o_sums = r_sums;
    assign o_fin  = r_fin;

endmodule

// ----- rtl/esa_unit.sv -----
module esa_unit import esa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_unit_cmd         i_cmd,
    output logic              o_done,
    output logic [WIDE_W-1:0] o_res
);

    logic                r_busy;
    logic                r_done;
    t_op                 r_op;
    logic [STEP_W-1:0]   r_cnt;
    logic [WIDE_W-1:0]   r_acc;
    logic [WIDE_W-1:0]   r_m;
    logic [SQ_W-1:0]     r_b;
    logic [CNT_W-1:0]    r_rem;

    logic                n_busy;
    logic                n_done;
    t_op                 n_op;
    logic [STEP_W-1:0]   n_cnt;
    logic [WIDE_W-1:0]   n_acc;
    logic [WIDE_W-1:0]   n_m;
    logic [SQ_W-1:0]     n_b;
    logic [CNT_W-1:0]    n_rem;

    logic [WIDE_W-1:0]   w_mul_sum;
    logic [CNT_W:0]      w_rem_sh;
    logic [CNT_W:0]      w_rem_sub;
    logic                w_div_ge;
    logic [SQ_W:0]       w_rt_sum;
    logic                w_rt_ge;

    assign w_mul_sum = r_acc + (r_b[0] ? r_m : '0);
    assign w_rem_sh  = {r_rem, r_acc[WIDE_W-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_b[CNT_W-1:0]};
    assign w_div_ge  = w_rem_sh >= {1'b0, r_b[CNT_W-1:0]};
    assign w_rt_sum  = {1'b0, r_acc[SQ_W-1:0]} + {1'b0, r_b};
    assign w_rt_ge   = {1'b0, r_m[SQ_W-1:0]} >= w_rt_sum;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_m    = r_m;
        n_b    = r_b;
        n_rem  = r_rem;
        if (i_cmd.start) begin
            n_busy = 1'b1;
            n_op   = i_cmd.op;
            case (i_cmd.op)
                OP_MUL: begin
                    n_acc = '0;
                    n_m   = i_cmd.opa;
                    n_b   = i_cmd.opb;
                    n_cnt = STEP_W'(MUL_STEPS - 1);
                end
                OP_DIV: begin
                    n_acc = i_cmd.opa;
                    n_rem = '0;
                    n_b   = i_cmd.opb;
                    n_cnt = STEP_W'(DIV_STEPS - 1);
                end
                OP_SQRT: begin
                    n_acc = '0;
                    n_m   = i_cmd.opa;
                    n_b   = SQ_W'(1) << (SQ_W - 2);
                    n_cnt = STEP_W'(SQRT_STEPS - 1);
                end
                default: begin
                    n_busy = 1'b0;
                end
            endcase
        end else if (r_busy) begin
            case (r_op)
                OP_MUL: begin
                    n_acc = w_mul_sum;
                    n_m   = r_m << 1;
                    n_b   = r_b >> 1;
                end
                OP_DIV: begin
                    // restoring division, one quotient bit per step
                    n_rem = w_div_ge ? w_rem_sub[CNT_W-1:0] : w_rem_sh[CNT_W-1:0];
                    n_acc = {r_acc[WIDE_W-2:0], w_div_ge};
                end
                OP_SQRT: begin
                    if (w_rt_ge) begin
                        n_m   = WIDE_W'(r_m[SQ_W-1:0] - w_rt_sum[SQ_W-1:0]);
                        n_acc = WIDE_W'((r_acc[SQ_W-1:0] >> 1) + r_b);
                    end else begin
                        n_acc = WIDE_W'(r_acc[SQ_W-1:0] >> 1);
                    end
                    n_b = r_b >> 2;
                end
                default: begin
                    n_acc = r_acc;
                end
            endcase
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_op  <= n_op;
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_m   <= n_m;
        r_b   <= n_b;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_res  = r_acc;

endmodule

// ----- rtl/esa_ctrl.sv -----
module esa_ctrl import esa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_accum_sums         i_sums,
    input  logic                i_fin,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic                o_clear,
    output logic [ACC_W-1:0]    o_accuracy,
    output logic [SAMPLE_W-1:0] o_mae,
    output logic [SAMPLE_W-1:0] o_rms,
    output logic [SAMPLE_W-1:0] o_dev,
    output t_status             o_status
);

    t_fin_state          r_state;
    t_fin_state          n_state;
    logic                r_issued;
    logic [ACC_W-1:0]    r_accuracy;
    logic [SAMPLE_W-1:0] r_mae;
    logic [SAMPLE_W-1:0] r_rms;
    logic [SAMPLE_W-1:0] r_dev;
    logic [WIDE_W-1:0]   r_big;

    t_unit_cmd           w_cmd;
    logic                w_done;
    logic [WIDE_W-1:0]   w_res;
    logic [CNT_W-1:0]    w_n;
    logic [WIDE_W-1:0]   w_n_half;
    logic                w_work;
    logic [WIDE_W-1:0]   w_num;

    assign w_n      = i_sums.pairs;
    assign w_n_half = WIDE_W'(w_n >> 1);
    // n*square_sum - abs_sum^2, taken as zero when the sums saturated below it
    assign w_num    = (r_big >= w_res) ? (r_big - w_res) : '0;

    esa_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_done  (w_done),
        .o_res   (w_res)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            FS_IDLE:     if (i_fin) n_state = FS_ACC_MUL;
            FS_ACC_MUL:  if (w_done) n_state = FS_ACC_DIV;
            FS_ACC_DIV:  if (w_done) n_state = FS_MAE_DIV;
            FS_MAE_DIV:  if (w_done) n_state = FS_RMS_DIV;
            FS_RMS_DIV:  if (w_done) n_state = FS_RMS_SQRT;
            FS_RMS_SQRT: begin
                if (w_done) n_state = (w_n >= CNT_W'(2)) ? FS_BIG_MUL : FS_OUT;
            end
            FS_BIG_MUL:  if (w_done) n_state = FS_S2_MUL;
            FS_S2_MUL:   if (w_done) n_state = FS_DEV_DIV1;
            FS_DEV_DIV1: if (w_done) n_state = FS_DEV_DIV2;
            FS_DEV_DIV2: if (w_done) n_state = FS_DEV_SQRT;
            FS_DEV_SQRT: if (w_done) n_state = FS_OUT;
            FS_OUT:      if (i_out_ready) n_state = FS_IDLE;
            default:     n_state = FS_IDLE;
        endcase
    end

    // outputs and unit operands
    always_comb begin
        w_work      = 1'b1;
        o_out_valid = 1'b0;
        o_clear     = 1'b0;
        w_cmd.op    = OP_DIV;
        w_cmd.opa   = '0;
        w_cmd.opb   = SQ_W'(w_n);
        case (r_state)
            FS_ACC_MUL: begin
                w_cmd.op  = OP_MUL;
                w_cmd.opa = WIDE_W'(i_sums.match_cnt);
                w_cmd.opb = SQ_W'(PERCENT_SQ);
            end
            FS_ACC_DIV: w_cmd.opa = w_res + w_n_half;
            FS_MAE_DIV: w_cmd.opa = WIDE_W'(i_sums.abs_sum) + w_n_half;
            FS_RMS_DIV: w_cmd.opa = WIDE_W'(i_sums.sq_sum);
            FS_RMS_SQRT: begin
                w_cmd.op  = OP_SQRT;
                w_cmd.opa = w_res;
            end
            FS_BIG_MUL: begin
                w_cmd.op  = OP_MUL;
                w_cmd.opa = WIDE_W'(i_sums.sq_sum);
            end
            FS_S2_MUL: begin
                w_cmd.op  = OP_MUL;
                w_cmd.opa = WIDE_W'(i_sums.abs_sum);
                w_cmd.opb = SQ_W'(i_sums.abs_sum);
            end
            FS_DEV_DIV1: w_cmd.opa = w_num;
            FS_DEV_DIV2: begin
                w_cmd.opa = w_res;
                w_cmd.opb = SQ_W'(w_n - 1'b1);
            end
            FS_DEV_SQRT: begin
                w_cmd.op  = OP_SQRT;
                w_cmd.opa = (w_res[WIDE_W-1:SQ_W] != '0) ? WIDE_W'({SQ_W{1'b1}})
                                                          : WIDE_W'(w_res[SQ_W-1:0]);
            end
            FS_OUT: begin
                w_work      = 1'b0;
                o_out_valid = 1'b1;
                o_clear     = i_out_ready;
            end
            default: w_work = 1'b0;
        endcase
        w_cmd.start = w_work && !r_issued;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= FS_IDLE;
            r_issued <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_done) begin
                r_issued <= 1'b0;
            end else if (w_cmd.start) begin
                r_issued <= 1'b1;
            end
        end
        if (r_state == FS_IDLE && i_fin) begin
            r_dev <= '0;
        end
        if (w_done) begin
            case (r_state)
                FS_ACC_DIV:  r_accuracy <= w_res[ACC_W-1:0];
                FS_MAE_DIV:  r_mae      <= w_res[SAMPLE_W-1:0];
                FS_RMS_SQRT: r_rms      <= w_res[SAMPLE_W-1:0];
                FS_BIG_MUL:  r_big      <= w_res;
                FS_DEV_SQRT: r_dev      <= w_res[SAMPLE_W-1:0];
                default:     r_big      <= r_big;
            endcase
        end
    end

    assign o_accuracy = r_accuracy;
    assign o_mae      = r_mae;
    assign o_rms      = r_rms;
    assign o_dev      = r_dev;
    assign o_status   = i_sums.ovf ? STAT_SATURATED
                      : ((w_n == CNT_W'(1)) ? STAT_SINGLE : STAT_OK);

endmodule

// ----- rtl/error_statistics_accumulator.sv -----
// Error statistics accumulator.
// Slave stream: one item per pair, tdata = {sample_b, sample_a} (signed Q16.16),
// tlast marks the final pair of a set. Master stream: one item per set, carrying
// pair and match counts, accuracy in hundredths of a percent, mean absolute
// error, rms error and sample deviation (unsigned Q16.16); tuser holds status
// (0 ok, 1 single pair, 2 sums saturated).
// Pairs without tlast are taken at one per cycle through a three stage
// accumulate pipe (difference, 32x32 square, sums). After an item with tlast,
// tready drops and one shared shift-add / restoring-divide / bit-pair root
// unit runs ten operations of 32 to 96 steps each (five when the set has one
// pair), and then tvalid rises.
// The result waits in its output registers while the receiver stalls;
// tready returns the cycle after the result is taken, with all sums cleared.
// Synchronous active-low reset clears the sums, drops m_axis_tvalid and raises tready.
module error_statistics_accumulator import esa_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [31:0] sample_a, [63:32] sample_b
    input  logic [63:0]  s_axis_tdata,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [16:0] pair_count, [33:17] match_count, [47:34] accuracy,
    // [79:48] mean_abs_error, [111:80] rms_error, [143:112] deviation
    output logic [143:0] m_axis_tdata,
    // [1:0] status
    output logic [1:0]   m_axis_tuser
);

    logic                r_hold;
    logic                w_take;
    logic                w_fin;
    logic                w_clear;
    t_accum_sums         w_sums;
    logic [ACC_W-1:0]    w_accuracy;
    logic [SAMPLE_W-1:0] w_mae;
    logic [SAMPLE_W-1:0] w_rms;
    logic [SAMPLE_W-1:0] w_dev;
    t_status             w_status;

    assign s_axis_tready = !r_hold;
    assign w_take        = s_axis_tvalid && !r_hold;

    // stop taking items from the last one of a set until its result is gone
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= 1'b0;
        end else if (w_take && s_axis_tlast) begin
            r_hold <= 1'b1;
        end else if (w_clear) begin
            r_hold <= 1'b0;
        end
    end

    esa_accum u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (w_take),
        .i_sample_a (s_axis_tdata[SAMPLE_W-1:0]),
        .i_sample_b (s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .i_last     (s_axis_tlast),
        .i_clear    (w_clear),
        .o_sums     (w_sums),
        .o_fin      (w_fin)
    );

    esa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sums      (w_sums),
        .i_fin       (w_fin),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_clear     (w_clear),
        .o_accuracy  (w_accuracy),
        .o_mae       (w_mae),
        .o_rms       (w_rms),
        .o_dev       (w_dev),
        .o_status    (w_status)
    );

    assign m_axis_tdata = {w_dev, w_rms, w_mae, w_accuracy, w_sums.match_cnt, w_sums.pairs};
    assign m_axis_tuser = w_status;

endmodule

// ----- rtl/esa_checker.sv -----
module esa_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [63:0]  s_axis_tdata,
    input logic         s_axis_tlast,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [143:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // nothing is taken after the last item of a set
    a_stop_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("item taken after last item");

    a_no_take_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input open while result pending");

    a_resume: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready |=> s_axis_tready && !m_axis_tvalid)
        else $error("input not reopened after result");

    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[47:34] <= 14'd10000
                          && m_axis_tdata[33:17] <= m_axis_tdata[16:0])
        else $error("accuracy or match count out of range");

endmodule

bind error_statistics_accumulator esa_checker u_esa_checker (.*);

// ----- bench/tb_error_statistics_accumulator.sv -----
`timescale 1ns / 100ps

module tb_error_statistics_accumulator;
    import esa_pkg::*;

    localparam int QUIET_LIMIT = 12000;
    localparam int DRAIN_CYCLES = 1000;
    localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S_MIN = 32'h8000_0000;

    typedef struct {
        logic [16:0] pairs;
        logic [16:0] match_cnt;
        logic [13:0] accuracy;
        logic [31:0] mae;
        logic [31:0] rms;
        logic [31:0] dev;
        t_status     status;
    } t_set_stats;

    logic         i_clk;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata = '0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [143:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    error_statistics_accumulator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // running sums of the set in progress
    logic [16:0] pair_tally;
    logic [16:0] match_tally;
    logic [47:0] abs_total;
    logic [63:0] sq_total;
    logic        sat_flag;

    t_set_stats pending_stats[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int pairs_sent = 0;
    int sets_checked = 0;
    int saturated_sets = 0;
    int quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [31:0] root64(input logic [63:0] x);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] probe;
        rem = x;
        res = '0;
        probe = 64'h1 << 62;
        while (probe > rem) probe = probe >> 2;
        while (probe != 0) begin
            if (rem >= res + probe) begin
                rem = rem - (res + probe);
                res = (res >> 1) + probe;
            end else begin
                res = res >> 1;
            end
            probe = probe >> 2;
        end
        return res[31:0];
    endfunction

    function automatic void clear_sums();
        pair_tally = '0;
        match_tally = '0;
        abs_total = '0;
        sq_total = '0;
        sat_flag = 1'b0;
    endfunction

    // fold one accepted pair into the sums; on the final pair queue the set statistics
    function automatic void tally_pair(input logic [31:0] a, input logic [31:0] b,
                                       input logic is_last);
        logic signed [32:0] delta;
        logic [31:0]  mag;
        logic [63:0]  sq;
        logic [64:0]  sq_next;
        logic [127:0] nn;
        logic [127:0] big;
        logic [127:0] s2;
        logic [127:0] num;
        logic [127:0] quo;
        logic [63:0]  var_w;
        logic [63:0]  tmp;
        t_set_stats   st;
        delta = $signed({a[31], a}) - $signed({b[31], b});
        mag = delta[32] ? (~delta[31:0] + 32'd1) : delta[31:0];
        if (pair_tally >= MAX_PAIRS) begin
            sat_flag = 1'b1;
        end else begin
            sq = {32'd0, mag} * {32'd0, mag};
            pair_tally++;
            if (mag == 0) match_tally++;
            abs_total = abs_total + {16'd0, mag};
            sq_next = {1'b0, sq_total} + {1'b0, sq};
            if (sq_next[64]) begin
                sq_total = '1;
                sat_flag = 1'b1;
            end else begin
                sq_total = sq_next[63:0];
            end
        end
        if (!is_last) return;

        nn = 128'(pair_tally);
        st.pairs = pair_tally;
        st.match_cnt = match_tally;
        tmp = (64'(match_tally) * 64'(PERCENT_SQ) + 64'(nn[63:0] >> 1)) / nn[63:0];
        st.accuracy = tmp[13:0];
        tmp = (64'(abs_total) + (nn[63:0] >> 1)) / nn[63:0];
        st.mae = tmp[31:0];
        st.rms = root64(sq_total / nn[63:0]);
        st.dev = '0;
        if (pair_tally >= 2) begin
            big = 128'(sq_total) * nn;
            s2 = 128'(abs_total) * 128'(abs_total);
            num = (big < s2) ? 128'd0 : big - s2;
            quo = num / nn / (nn - 128'd1);
            var_w = (quo[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : quo[63:0];
            st.dev = root64(var_w);
        end
        st.status = sat_flag ? STAT_SATURATED : (pair_tally == 1 ? STAT_SINGLE : STAT_OK);
        pending_stats.push_back(st);
        clear_sums();
    endfunction

    task automatic send_pair(input logic [31:0] a, input logic [31:0] b, input logic is_last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {b, a};
        s_axis_tlast <= is_last;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        tally_pair(a, b, is_last);
        pairs_sent++;
    endtask

    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // receiver: random backpressure, compare every result with the oldest pending set
    always @(posedge i_clk) begin
        t_set_stats exp_s;
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_stats.size() == 0) begin
                $error("result with no set pending: tdata=%h tuser=%0d",
                       m_axis_tdata, m_axis_tuser);
                errors++;
            end else begin
                exp_s = pending_stats.pop_front();
                sets_checked++;
                if (exp_s.status == STAT_SATURATED) saturated_sets++;
                if (m_axis_tdata[16:0] !== exp_s.pairs) begin
                    $error("pair_count expected %0d got %0d", exp_s.pairs, m_axis_tdata[16:0]);
                    errors++;
                end
                if (m_axis_tdata[33:17] !== exp_s.match_cnt) begin
                    $error("match_count expected %0d got %0d",
                           exp_s.match_cnt, m_axis_tdata[33:17]);
                    errors++;
                end
                if (m_axis_tdata[47:34] !== exp_s.accuracy) begin
                    $error("accuracy expected %0d got %0d", exp_s.accuracy, m_axis_tdata[47:34]);
                    errors++;
                end
                if (m_axis_tdata[79:48] !== exp_s.mae) begin
                    $error("mean_abs_error expected %h got %h", exp_s.mae, m_axis_tdata[79:48]);
                    errors++;
                end
                if (m_axis_tdata[111:80] !== exp_s.rms) begin
                    $error("rms_error expected %h got %h", exp_s.rms, m_axis_tdata[111:80]);
                    errors++;
                end
                if (m_axis_tdata[143:112] !== exp_s.dev) begin
                    $error("deviation expected %h got %h", exp_s.dev, m_axis_tdata[143:112]);
                    errors++;
                end
                if (m_axis_tuser !== exp_s.status) begin
                    $error("status expected %0d got %0d", exp_s.status, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
            $display("** error_statistics_accumulator: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic test_field_extremes();
        send_pair(S_MIN, S_MIN, 1'b0);
        send_pair(S_MAX, S_MAX, 1'b0);
        send_pair(32'd0, 32'hFFFF_FFFF, 1'b0);
        send_pair(32'd1, 32'd0, 1'b0);
        send_pair(S_MAX, 32'd0, 1'b0);
        send_pair(32'h0001_0000, 32'h0001_8000, 1'b1);
    endtask

    task automatic test_single_pair();
        send_pair(S_MAX, S_MIN, 1'b1);
        send_pair(32'd0, 32'd0, 1'b1);
        send_pair(S_MIN, S_MAX, 1'b1);
    endtask

    task automatic test_rounding();
        // one match in three, odd sum of differences over two pairs
        send_pair(32'd2, 32'd2, 1'b0);
        send_pair(32'd0, 32'd1, 1'b0);
        send_pair(32'd5, 32'd0, 1'b1);
        send_pair(32'd7, 32'd7, 1'b0);
        send_pair(32'd0, 32'd3, 1'b0);
        send_pair(32'd0, 32'd0, 1'b1);
        send_pair(32'd1, 32'd0, 1'b0);
        send_pair(32'd5, 32'd5, 1'b1);
    endtask

    task automatic test_saturation();
        // square sum sticks at all ones and the variance numerator goes negative
        repeat (2) send_pair(S_MAX, S_MIN, 1'b0);
        send_pair(S_MAX, S_MIN, 1'b1);
        send_pair(S_MIN, S_MAX, 1'b0);
        send_pair(S_MIN, S_MAX, 1'b1);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return S_MAX;
            1: return S_MIN;
            2: return 32'd0;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
        int left;
        int set_len;
        int pick;
        logic [31:0] a;
        logic [31:0] b;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        left = count;
        while (left > 0) begin
            pick = $urandom_range(99);
            if (pick < 12) set_len = 1;
            else if (pick < 75) set_len = $urandom_range(2, 8);
            else if (pick < 95) set_len = $urandom_range(9, 32);
            else set_len = $urandom_range(33, 96);
            if (set_len > left) set_len = left;
            for (int k = 0; k < set_len; k++) begin
                a = $urandom;
                case ($urandom_range(9))
                    0, 1, 2: b = a;
                    3, 4, 5: b = a + $urandom_range(255) - 128;
                    6, 7: b = a + {{16{1'b0}}, 16'($urandom)};
                    8: b = $urandom;
                    default: begin
                        a = pick_value();
                        b = pick_value();
                    end
                endcase
                send_pair(a, b, k == set_len - 1);
            end
            left -= set_len;
        end
    endtask

    initial begin
        clear_sums();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_field_extremes();
        test_single_pair();
        test_rounding();
        // hold off until every set has reported
        wait_results();
        test_saturation();
        wait_results();

        test_random_traffic(0, 0, 490);
        test_random_traffic(51, 0, 490);
        test_random_traffic(0, 51, 490);
        test_random_traffic(24, 24, 490);

        s_axis_tlast <= 1'b0;
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d pairs in %0d sets, %0d of them saturated",
                 pairs_sent, sets_checked, saturated_sets);
        $display("with single-pair sets, rounding cases and all four backpressure mixes");
        if (errors == 0 && pending_stats.size() == 0) begin
            $display("** error_statistics_accumulator: PASSED **");
        end else begin
            $display("** error_statistics_accumulator: FAILED **");
        end
        $finish;
    end

endmodule
